### hdl/base64_stream_encoder_assert.svh
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// consequence holds in the same cycle
`define B64SE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the next cycle
`define B64SE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/b64se_pkg.sv
package b64se_pkg;

  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    PHASE_0 = 2'd0,
    PHASE_1 = 2'd1,
    PHASE_2 = 2'd2
  } phase_t;

  localparam logic ALPHA_STD = 1'b0;
  localparam logic ALPHA_URL = 1'b1;

  typedef struct packed {
    logic [5:0] sx0;
    logic [5:0] sx1;
    logic       two;
    logic       last;
  } b64se_entry_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v, input logic mode);
    logic [6:0] c;
    begin
      if (v < 6'd26) begin
        c = 7'(v) + 7'd65;
      end else if (v < 6'd52) begin
        c = 7'(v) + 7'd71;
      end else if (v < 6'd62) begin
        c = 7'(v) - 7'd4;
      end else if (v == 6'd62) begin
        c = (mode == ALPHA_URL) ? 7'd45 : 7'd43;
      end else begin
        c = (mode == ALPHA_URL) ? 7'd95 : 7'd47;
      end
      return c;
    end
  endfunction

endpackage

### hdl/b64se_byte_if.sv
interface b64se_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

### hdl/b64se_char_if.sv
interface b64se_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_char;

  modport source(output valid, char_code, last_char, input ready);
  modport sink(input valid, char_code, last_char, output ready);
endinterface

### hdl/b64se_front.sv
module b64se_front (
  input  logic                    clk,
  input  logic                    rst,
  b64se_byte_if.sink              in_ch,
  input  logic                    full,
  output logic                    push,
  output b64se_pkg::b64se_entry_t push_data
);
  import b64se_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] leftover;
  logic [3:0] leftover_next;
  logic [7:0] b;

  assign in_ch.ready = !full;
  assign push = in_ch.valid && !full;
  assign b = in_ch.data_byte;

  always_comb begin
    push_data.sx0 = b[7:2];
    push_data.sx1 = 6'd0;
    push_data.two = 1'b0;
    push_data.last = 1'b0;
    phase_next = PHASE_0;
    leftover_next = 4'd0;
    case (phase)
      PHASE_1: begin
        push_data.sx0 = {leftover[1:0], b[7:4]};
        if (in_ch.last_byte) begin
          push_data.sx1 = {b[3:0], 2'b00};
          push_data.two = 1'b1;
          push_data.last = 1'b1;
        end else begin
          phase_next = PHASE_2;
          leftover_next = b[3:0];
        end
      end
      PHASE_2: begin
        push_data.sx0 = {leftover, b[7:6]};
        push_data.sx1 = b[5:0];
        push_data.two = 1'b1;
        push_data.last = in_ch.last_byte;
      end
      default: begin
        push_data.sx0 = b[7:2];
        if (in_ch.last_byte) begin
          push_data.sx1 = {b[1:0], 4'b0000};
          push_data.two = 1'b1;
          push_data.last = 1'b1;
        end else begin
          phase_next = PHASE_1;
          leftover_next = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_0;
      leftover <= 4'd0;
    end else if (push) begin
      phase <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

### hdl/b64se_queue.sv
`include "base64_stream_encoder_assert.svh"

module b64se_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  b64se_pkg::b64se_entry_t push_data,
  output logic                    full,
  input  logic                    pop,
  output b64se_pkg::b64se_entry_t pop_data,
  output logic                    empty
);
  import b64se_pkg::*;

  b64se_entry_t   slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `B64SE_ASSERT_SAME(a_no_push_full, clk, rst, full, !push, "push into full queue")
  `B64SE_ASSERT_SAME(a_no_pop_empty, clk, rst, empty, !pop, "pop from empty queue")
  `B64SE_ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, !empty, "queue empty after push")

endmodule

### hdl/b64se_back.sv
module b64se_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic                    wr_data,
  input  logic                    empty,
  input  b64se_pkg::b64se_entry_t pop_data,
  output logic                    pop,
  b64se_char_if.source            out_ch
);
  import b64se_pkg::*;

  logic       alphabet_mode;
  logic       sel;
  logic       out_valid;
  logic [6:0] char_code;
  logic       last_char;
  logic       load;
  logic       final_char;
  logic [5:0] sextet;

  assign load = !empty && (!out_valid || out_ch.ready);
  assign final_char = !pop_data.two || sel;
  assign pop = load && final_char;
  assign sextet = sel ? pop_data.sx1 : pop_data.sx0;

  assign out_ch.valid = out_valid;
  assign out_ch.char_code = char_code;
  assign out_ch.last_char = last_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_mode <= ALPHA_STD;
    end else if (wr_en) begin
      alphabet_mode <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel <= !final_char;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_code <= sextet_char(sextet, alphabet_mode);
      last_char <= pop_data.last && final_char;
    end
  end

endmodule

### hdl/base64_stream_encoder.sv
// base64 encoder for a byte stream, no '=' padding
// in_ch carries one message byte per transfer with last_byte marking the
// end of the message; out_ch carries one ascii character per transfer with
// last_char on the final character of the message
// wr_en/wr_data write alphabet_mode: 0 standard (+ /), 1 url safe (- _)
// a byte yields one or two characters: two in the third byte of a group and
// on the last byte, where leftover bits are flushed zero filled
// the first character of a byte passes through the queue and the output
// register; the second is loaded once out_ch takes the first
// throughput: one character per cycle while out_ch.ready is high, set by the
// single output register; a long message needs four characters per three
// bytes, and a byte that ends a message needs two characters
// a two entry queue decouples byte intake from character output; when the
// receiver stalls the output holds and in_ch.ready drops once the queue fills
// reset (rst, synchronous) empties the queue, drops out_ch.valid, returns to
// the start of a group and selects the standard alphabet
module base64_stream_encoder (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic         wr_data,
  b64se_byte_if.sink   in_ch,
  b64se_char_if.source out_ch
);
  import b64se_pkg::*;

  b64se_entry_t push_data;
  b64se_entry_t pop_data;
  logic         push;
  logic         pop;
  logic         full;
  logic         empty;

  b64se_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  b64se_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  b64se_back u_back (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_data  (wr_data),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
